@@ rtl/msfl_pkg.sv @@
// ----------------------------------------------------------------------------
// msfl_pkg
// Shared types and constants for the multi-stack free-list manager.
// ----------------------------------------------------------------------------
package msfl_pkg;

  localparam int DATA_W         = 32;
  localparam int ID_W           = 3;
  localparam int NUM_STACKS_DEF = 8;
  localparam int CAPACITY_DEF   = 1024;

  // operation codes carried in the func field
  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC
  } msfl_state_t;

endpackage

@@ rtl/msfl_ifs.sv @@
// ----------------------------------------------------------------------------
// msfl_ifs
// Valid/ready channels for request and result words.
// ----------------------------------------------------------------------------
interface msfl_in_if
  import msfl_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic                     func;
  logic [ID_W-1:0]          stack_id;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output func, output stack_id, output value, input ready);
  modport sink   (input valid, input func, input stack_id, input value, output ready);
endinterface

interface msfl_out_if
  import msfl_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic                     ok;
  logic signed [DATA_W-1:0] pop_value;

  modport source (output valid, output ok, output pop_value, input ready);
  modport sink   (input valid, input ok, input pop_value, output ready);
endinterface

@@ rtl/multi_stack_free_list_manager_core.sv @@
// ----------------------------------------------------------------------------
// multi_stack_free_list_manager_core
// Several LIFO stacks sharing one slot store, slots handed out from a free list.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : request words {func, stack_id, value}; func 0 pushes value onto
//            stack_id, func 1 pops from it.
//   out_ch : one result word per request {ok, pop_value}. A push gives ok=1 and
//            pop_value=0, or ok=0 when no slot is free. A pop gives the word
//            with ok=1, or ok=0 and -1 when the stack is empty. A stack_id of
//            NUM_STACKS or more fails the same way.
//   Timing : one request at a time. After acceptance the sequencer reads the
//            slot's link and data words from the two RAMs (ST_READ), then
//            writes back and loads the output register (ST_EXEC), and only
//            then returns to ST_IDLE, where the next request is taken.
//   Stall  : the result sits in an output register. A new request is accepted
//            while it waits; the write-back step holds until it is taken.
//   Reset  : rst_n (synchronous, active low) empties all stacks and makes the
//            whole store free. Untouched link entries are covered by a fill
//            count, so no clearing pass is needed and requests are accepted
//            in the first cycle after reset.
// ----------------------------------------------------------------------------
module multi_stack_free_list_manager_core
  import msfl_pkg::*;
#(
  parameter int NUM_STACKS = NUM_STACKS_DEF,
  parameter int CAPACITY   = CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  msfl_in_if.sink    in_ch,
  msfl_out_if.source out_ch
);

  localparam int AW  = $clog2(CAPACITY);       // slot address width
  localparam int PW  = $clog2(CAPACITY + 1);   // pointer width, holds the null code
  localparam int SW  = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int IXW = (SW > ID_W) ? SW : ID_W;
  localparam logic [PW-1:0] NULL_PTR = PW'(CAPACITY);

  // pointer state
  logic [PW-1:0] tops_r [NUM_STACKS];
  logic [PW-1:0] free_head_r, free_head_nxt;
  logic [PW-1:0] fill_r, fill_nxt;             // slots ever handed out in order

  // request held through the sequence
  msfl_state_t              state_r, state_nxt;
  logic                     func_r;
  logic [SW-1:0]            sid_r;
  logic signed [DATA_W-1:0] value_r;
  logic [PW-1:0]            slot_r;
  logic                     fail_r;

  // result register
  logic                     out_valid_r, out_valid_nxt;
  logic                     out_ok_r;
  logic signed [DATA_W-1:0] out_value_r;

  // RAM ports
  logic [PW-1:0]     link_rd;
  logic [DATA_W-1:0] data_rd;
  logic              mem_rd_en;
  logic              link_wr_en, data_wr_en;
  logic [PW-1:0]     link_wr_data;

  // decode of the incoming word
  logic [IXW-1:0] sid_wide;
  logic [SW-1:0]  sid_in;
  logic           sid_ok;
  logic [PW-1:0]  slot_in;
  logic           accept;

  // write-back step
  logic          exec_go;
  logic          do_update;
  logic          virgin;
  logic [PW-1:0] link_val;
  logic [PW-1:0] link_norm;
  logic [PW-1:0] top_cur;
  logic          top_wr;
  logic [PW-1:0] top_wr_data;

  assign accept   = in_ch.valid && in_ch.ready;
  assign sid_wide = IXW'(in_ch.stack_id);
  assign sid_in   = sid_wide[SW-1:0];
  assign sid_ok   = int'(in_ch.stack_id) < NUM_STACKS;
  assign slot_in  = (in_ch.func == FUNC_POP) ? tops_r[sid_in] : free_head_r;

  assign top_cur  = tops_r[sid_r];

  // a slot at or past the fill count was never written: its link is slot + 1
  assign virgin    = slot_r >= fill_r;
  assign link_val  = virgin ? (slot_r + PW'(1)) : link_rd;
  assign link_norm = (link_val >= NULL_PTR) ? NULL_PTR : link_val;

  // sequencer: next state and strobes
  always_comb begin
    state_nxt     = state_r;
    in_ch.ready   = 1'b0;
    mem_rd_en     = 1'b0;
    exec_go       = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    unique case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        mem_rd_en = 1'b1;
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        // hold until the output register is free
        if (!out_valid_r || out_ch.ready) begin
          exec_go       = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // pointer updates for a successful operation
  assign do_update = exec_go && !fail_r;

  always_comb begin
    free_head_nxt = free_head_r;
    fill_nxt      = fill_r;
    link_wr_en    = 1'b0;
    data_wr_en    = 1'b0;
    link_wr_data  = top_cur;
    top_wr        = 1'b0;
    top_wr_data   = slot_r;
    if (do_update) begin
      link_wr_en = 1'b1;
      top_wr     = 1'b1;
      if (func_r == FUNC_PUSH) begin
        // take the free head, link it above the old top
        data_wr_en    = 1'b1;
        link_wr_data  = top_cur;
        top_wr_data   = slot_r;
        free_head_nxt = link_norm;
        if (virgin) begin
          fill_nxt = fill_r + PW'(1);
        end
      end else begin
        // unlink the top, return it to the free list
        link_wr_data  = free_head_r;
        top_wr_data   = link_norm;
        free_head_nxt = slot_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      free_head_r <= '0;
      fill_r      <= '0;
      for (int i = 0; i < NUM_STACKS; i++) begin
        tops_r[i] <= NULL_PTR;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      free_head_r <= free_head_nxt;
      fill_r      <= fill_nxt;
      if (top_wr) begin
        tops_r[sid_r] <= top_wr_data;
      end
    end
  end

  // request capture and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r  <= in_ch.func;
      sid_r   <= sid_in;
      value_r <= in_ch.value;
      slot_r  <= slot_in;
      fail_r  <= !sid_ok || (slot_in >= NULL_PTR);
    end
    if (exec_go) begin
      out_ok_r <= !fail_r;
      if (func_r == FUNC_PUSH) begin
        out_value_r <= '0;
      end else if (fail_r) begin
        out_value_r <= '1;
      end else begin
        out_value_r <= data_rd;
      end
    end
  end

  msfl_ram #(
    .WIDTH (PW),
    .DEPTH (CAPACITY)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (link_wr_en),
    .wr_addr (slot_r[AW-1:0]),
    .wr_data (link_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (slot_r[AW-1:0]),
    .rd_data (link_rd)
  );

  msfl_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_data_ram (
    .clk     (clk),
    .wr_en   (data_wr_en),
    .wr_addr (slot_r[AW-1:0]),
    .wr_data (value_r),
    .rd_en   (mem_rd_en),
    .rd_addr (slot_r[AW-1:0]),
    .rd_data (data_rd)
  );

  assign out_ch.valid     = out_valid_r;
  assign out_ch.ok        = out_ok_r;
  assign out_ch.pop_value = out_value_r;

endmodule

@@ rtl/msfl_ram.sv @@
// ----------------------------------------------------------------------------
// msfl_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module msfl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/msfl_checker.sv @@
// ----------------------------------------------------------------------------
// msfl_checker
// Port-level checks for the multi-stack free-list manager.
// ----------------------------------------------------------------------------
module msfl_checker
  import msfl_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_ok,
  input logic [DATA_W-1:0] out_pop_value
);

  // reset drops any pending result
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word valid after reset");

  // one request in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while another is in flight");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> ($stable(out_ok) && $stable(out_pop_value)))
    else $error("result word changed while stalled");

endmodule

bind multi_stack_free_list_manager_core msfl_checker u_msfl_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_ok        (out_ch.ok),
  .out_pop_value (out_ch.pop_value)
);
